[hw/rtl/sial_pkg.sv]
// Shared constants, request and status codes, and payload types of the array list unit.
`default_nettype none

package sial_pkg;

  localparam int DEPTH      = 128;
  localparam int WORD_WIDTH = 32;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  localparam logic [2:0] REQ_INSERT     = 3'd0;
  localparam logic [2:0] REQ_REMOVE     = 3'd1;
  localparam logic [2:0] REQ_READ       = 3'd2;
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd3;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd4;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd5;
  localparam logic [2:0] REQ_POP_BACK   = 3'd6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [7:0]         position;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [7:0]         entry_count;
    logic               empty_flag;
    logic               full_flag;
  } rsp_t;

  typedef struct packed {
    logic                  en;
    logic [AW-1:0]         addr;
    logic [WORD_WIDTH-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
  } ram_rd_t;

endpackage

`default_nettype wire

[hw/rtl/sial_store.sv]
// Entry store: one write port and one read port with registered read data.
`default_nettype none

module sial_store (
  input  wire                               clk,
  input  wire sial_pkg::ram_wr_t            wr,
  input  wire sial_pkg::ram_rd_t            rd,
  output logic [sial_pkg::WORD_WIDTH-1:0]   rd_data
);

  logic [sial_pkg::WORD_WIDTH-1:0] mem [sial_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/shift_insert_array_list_unit.sv]
// Top level of the array list unit: request decoding, shift sequencer and result register.
`default_nettype none

// The unit keeps an ordered list of up to DEPTH signed words in a single-port-write,
// single-port-read store, together with an entry count, and answers every request
// with exactly one result item carrying a status, the read word, the new count and
// the empty and full flags. Requests are taken one at a time: req_ready is high only
// while the sequencer is idle. The cost of a request is set by the one store port
// pair and the single index adder that walks it. An insert or push front moves each
// later entry up one place, reading it and then writing it back, and then writes the
// new word; a remove or pop front moves each later entry down one place the same way.
// A read fetches the word from the store, a push back only writes the new word, and
// a pop back, a rejected request or an unused request code goes straight to the final
// step. A finished result sits in an output register, so the unit goes back to idle
// and takes the next request while that result waits to be taken; it only holds in its
// final step if the previous result is still unclaimed. No clearing pass is needed
// after reset: only entries below the count are ever read.
module shift_insert_array_list_unit (
  input  wire                clk,
  input  wire                rst,
  input  wire                req_valid,
  output logic               req_ready,
  input  wire sial_pkg::req_t req,
  output logic               rsp_valid,
  input  wire                rsp_ready,
  output sial_pkg::rsp_t     rsp
);

  localparam int AW    = sial_pkg::AW;
  localparam int CNT_W = sial_pkg::CNT_W;
  localparam int CMP_W = sial_pkg::CMP_W;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_MOVE_RD = 6'b000010,
    S_MOVE_WR = 6'b000100,
    S_PUT     = 6'b001000,
    S_READ    = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t state;

  logic [CNT_W-1:0]                count;
  logic [AW-1:0]                   idx;
  logic [AW-1:0]                   pos_r;
  logic [sial_pkg::WORD_WIDTH-1:0] word_r;
  logic [1:0]                      status_r;
  logic signed [31:0]              rdv_r;
  logic                            open_r;
  logic                            inc_r;
  logic                            dec_r;

  logic                            accept;
  logic [CMP_W-1:0]                cnt_e;
  logic [CMP_W-1:0]                pos_e;
  logic [CMP_W-1:0]                eff_pos;
  logic                            is_full;
  logic                            is_empty;
  logic [1:0]                      dec_status;
  logic                            grows;
  logic                            shrinks;
  logic [AW-1:0]                   src;
  logic                            more_src;
  logic [CNT_W-1:0]                count_adj;
  logic                            rsp_free;

  sial_pkg::ram_wr_t               ram_wr;
  sial_pkg::ram_rd_t               ram_rd;
  logic [sial_pkg::WORD_WIDTH-1:0] ram_q;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;

  // Request decode against the current count. The rejection order follows the
  // list rules: an insert checks its index before fullness, a remove checks
  // emptiness before its index.
  always_comb begin
    cnt_e      = CMP_W'(count);
    pos_e      = CMP_W'(req.position);
    is_full    = (count == CNT_W'(sial_pkg::DEPTH));
    is_empty   = (count == '0);
    grows      = req.req_type inside {sial_pkg::REQ_INSERT, sial_pkg::REQ_PUSH_FRONT,
                                      sial_pkg::REQ_PUSH_BACK};
    shrinks    = req.req_type inside {sial_pkg::REQ_REMOVE, sial_pkg::REQ_POP_FRONT,
                                      sial_pkg::REQ_POP_BACK};
    dec_status = sial_pkg::ST_OK;
    case (req.req_type)
      sial_pkg::REQ_INSERT: begin
        if (pos_e > cnt_e) begin
          dec_status = sial_pkg::ST_BAD_INDEX;
        end else if (is_full) begin
          dec_status = sial_pkg::ST_FULL;
        end
      end
      sial_pkg::REQ_REMOVE: begin
        if (is_empty) begin
          dec_status = sial_pkg::ST_EMPTY;
        end else if (pos_e >= cnt_e) begin
          dec_status = sial_pkg::ST_BAD_INDEX;
        end
      end
      sial_pkg::REQ_READ: begin
        if (pos_e >= cnt_e) begin
          dec_status = sial_pkg::ST_BAD_INDEX;
        end
      end
      sial_pkg::REQ_PUSH_FRONT, sial_pkg::REQ_PUSH_BACK: begin
        if (is_full) begin
          dec_status = sial_pkg::ST_FULL;
        end
      end
      sial_pkg::REQ_POP_FRONT, sial_pkg::REQ_POP_BACK: begin
        if (is_empty) begin
          dec_status = sial_pkg::ST_EMPTY;
        end
      end
      default: begin
        dec_status = sial_pkg::ST_OK;
      end
    endcase

    // Front operations work at index zero and a push back at the current end.
    case (req.req_type)
      sial_pkg::REQ_PUSH_FRONT, sial_pkg::REQ_POP_FRONT: eff_pos = '0;
      sial_pkg::REQ_PUSH_BACK:                          eff_pos = cnt_e;
      default:                                          eff_pos = pos_e;
    endcase
  end

  // The shared index unit: one adder steps the cursor towards the source entry,
  // downwards when opening a gap and upwards when closing one.
  assign src = open_r ? (idx - AW'(1)) : (idx + AW'(1));

  // After moving into the cursor, more work remains while an opening walk has not
  // reached the target, or a closing walk has not reached the last entry.
  assign more_src = open_r ? (src != pos_r) : ((CNT_W'(src) + CNT_W'(1)) != count);

  assign count_adj = inc_r ? (count + CNT_W'(1)) :
                     dec_r ? (count - CNT_W'(1)) : count;

  // Store port control.
  always_comb begin
    ram_rd.en   = 1'b0;
    ram_rd.addr = src;
    ram_wr.en   = 1'b0;
    ram_wr.addr = idx;
    ram_wr.data = ram_q;
    case (state)
      S_IDLE: begin
        ram_rd.en   = accept && (req.req_type == sial_pkg::REQ_READ);
        ram_rd.addr = AW'(req.position);
      end
      S_MOVE_RD: begin
        ram_rd.en = 1'b1;
      end
      S_MOVE_WR: begin
        ram_wr.en = 1'b1;
      end
      S_PUT: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = pos_r;
        ram_wr.data = word_r;
      end
      default: begin
        ram_rd.en = 1'b0;
      end
    endcase
  end

  sial_store u_store (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (ram_q)
  );

  // Sequencer and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (dec_status != sial_pkg::ST_OK) begin
              state <= S_DONE;
            end else begin
              case (req.req_type)
                sial_pkg::REQ_INSERT, sial_pkg::REQ_PUSH_FRONT: begin
                  state <= (eff_pos == cnt_e) ? S_PUT : S_MOVE_RD;
                end
                sial_pkg::REQ_PUSH_BACK: begin
                  state <= S_PUT;
                end
                sial_pkg::REQ_REMOVE, sial_pkg::REQ_POP_FRONT: begin
                  state <= ((eff_pos + CMP_W'(1)) == cnt_e) ? S_DONE : S_MOVE_RD;
                end
                sial_pkg::REQ_READ: begin
                  state <= S_READ;
                end
                default: begin
                  state <= S_DONE;
                end
              endcase
            end
          end
        end
        S_MOVE_RD: begin
          state <= S_MOVE_WR;
        end
        S_MOVE_WR: begin
          if (more_src) begin
            state <= S_MOVE_RD;
          end else begin
            state <= open_r ? S_PUT : S_DONE;
          end
        end
        S_PUT: begin
          state <= S_DONE;
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_free) begin
            state     <= S_IDLE;
            count     <= count_adj;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The result is offered from the cycle after the final step until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_DONE) && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Request payload, cursor and result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r    <= AW'(eff_pos);
      word_r   <= req.item_value[sial_pkg::WORD_WIDTH-1:0];
      status_r <= dec_status;
      rdv_r    <= '0;
      open_r   <= grows;
      inc_r    <= grows && (dec_status == sial_pkg::ST_OK);
      dec_r    <= shrinks && (dec_status == sial_pkg::ST_OK);
      idx      <= grows ? count[AW-1:0] : AW'(eff_pos);
    end
    if (state == S_MOVE_WR) begin
      idx <= src;
    end
    if (state == S_READ) begin
      rdv_r <= 32'(signed'(ram_q));
    end
    if ((state == S_DONE) && rsp_free) begin
      rsp.status      <= status_r;
      rsp.read_value  <= rdv_r;
      rsp.entry_count <= 8'(count_adj);
      rsp.empty_flag  <= (count_adj == '0);
      rsp.full_flag   <= (count_adj == CNT_W'(sial_pkg::DEPTH));
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sial_checker.sv]
// Port-level checks of the array list unit and their attachment to the top level.
`default_nettype none

module sial_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 req_valid,
  input wire                 req_ready,
  input wire sial_pkg::req_t req,
  input wire                 rsp_valid,
  input wire                 rsp_ready,
  input wire sial_pkg::rsp_t rsp
);

  // A request that is not taken stays offered unchanged.
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request changed or dropped while waiting");

  // A result that is not taken stays offered unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed or dropped while stalled");

  // The flags agree with the reported count.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.empty_flag == (rsp.entry_count == 8'd0)) &&
                  (rsp.full_flag == (rsp.entry_count == 8'(sial_pkg::DEPTH))))
    else $error("empty or full flag disagrees with the count");

  // A full or empty rejection reports a list in that condition.
  a_reject: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ((rsp.status == sial_pkg::ST_FULL && !rsp.full_flag) ||
                  (rsp.status == sial_pkg::ST_EMPTY && !rsp.empty_flag)) |-> 1'b0)
    else $error("rejection status does not match the list condition");

  // Only a successful request may carry a nonzero read word.
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != sial_pkg::ST_OK) |-> (rsp.read_value == 32'sd0))
    else $error("read word is nonzero on a rejected request");

endmodule

bind shift_insert_array_list_unit sial_checker u_sial_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire
